// ===== design/tes_pkg.sv =====
`default_nettype none

package tes_pkg;

  localparam int TIME_W = 48;
  localparam int IVL_W  = 32;
  localparam int ID_W   = 4;
  localparam int CMD_W  = 2;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PRE_SCAN,
    S_ADD_WR,
    S_DUE_SCAN,
    S_PICK_SCAN,
    S_FIRE,
    S_REARM,
    S_SUM_SCAN,
    S_SUM
  } state_t;

  typedef struct packed {
    logic exp_en;
    logic ivl_en;
  } slot_wr_t;

endpackage

`default_nettype wire

// ===== design/tes_in_if.sv =====
`default_nettype none

interface tes_in_if;
  logic                       valid;
  logic                       ready;
  logic [tes_pkg::CMD_W-1:0]  cmd;
  logic [tes_pkg::ID_W-1:0]   timer_id;
  logic [tes_pkg::TIME_W-1:0] expiry_time;
  logic [tes_pkg::IVL_W-1:0]  repeat_interval;
  logic [tes_pkg::TIME_W-1:0] now_time;

  modport source (
    output valid, cmd, timer_id, expiry_time, repeat_interval, now_time,
    input  ready
  );
  modport sink (
    input  valid, cmd, timer_id, expiry_time, repeat_interval, now_time,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/tes_out_if.sv =====
`default_nettype none

interface tes_out_if;
  logic                       valid;
  logic                       ready;
  logic                       fired;
  logic [tes_pkg::ID_W-1:0]   fired_id;
  logic                       deadline_valid;
  logic [tes_pkg::TIME_W-1:0] next_deadline;
  logic                       earliest_changed;
  logic                       last;

  modport source (
    output valid, fired, fired_id, deadline_valid, next_deadline, earliest_changed, last,
    input  ready
  );
  modport sink (
    input  valid, fired, fired_id, deadline_valid, next_deadline, earliest_changed, last,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/tes_slot_mem.sv =====
`default_nettype none

module tes_slot_mem #(
  parameter int NUM_TIMERS = 16
) (
  input  logic                              clk,
  input  tes_pkg::slot_wr_t                 wr,
  input  logic [$clog2(NUM_TIMERS)-1:0]     wr_addr,
  input  logic [tes_pkg::TIME_W-1:0]        wr_exp,
  input  logic [tes_pkg::IVL_W-1:0]         wr_ivl,
  input  logic [$clog2(NUM_TIMERS)-1:0]     rd_addr,
  output logic [tes_pkg::TIME_W-1:0]        rd_exp,
  output logic [tes_pkg::IVL_W-1:0]         rd_ivl
);
  import tes_pkg::*;

  logic [TIME_W-1:0] mem_exp [NUM_TIMERS];
  logic [IVL_W-1:0]  mem_ivl [NUM_TIMERS];

  always_ff @(posedge clk) begin
    if (wr.exp_en) begin
      mem_exp[wr_addr] <= wr_exp;
    end
    if (wr.ivl_en) begin
      mem_ivl[wr_addr] <= wr_ivl;
    end
    rd_exp <= mem_exp[rd_addr];
    rd_ivl <= mem_ivl[rd_addr];
  end

endmodule

`default_nettype wire

// ===== design/timer_expiry_scheduler_core.sv =====
// cancel, unknown commands, out-of-range add: summary scan; add: pre-scan, slot write, summary scan;
// tick: due scan, then pick scan, fire and rearm per fired slot, last pick scan, summary scan
// every slot scan reads the slot memory one entry per cycle through its single read port
// and one shared 48-bit compare unit; one command in flight, next one taken once the summary is loaded
// reset clears the sequencer, the armed marks and the output valid flag
`default_nettype none

module timer_expiry_scheduler_core #(
  parameter int NUM_TIMERS = 16
) (
  input  logic             clk,
  input  logic             rst,
  tes_in_if.sink           req,
  tes_out_if.source        rsp
);
  import tes_pkg::*;

  localparam int IW = $clog2(NUM_TIMERS);
  localparam int CW = IW + 1;
  localparam int XW = CW + ID_W;

  state_t state;
  state_t state_next;

  logic [CW-1:0]     cnt;
  logic              rd_valid;
  logic [IW-1:0]     rd_idx;
  logic [NUM_TIMERS-1:0] armed;
  logic [NUM_TIMERS-1:0] due;

  logic [TIME_W-1:0] time_q;
  logic [IVL_W-1:0]  ivl_q;
  logic [IW-1:0]     id_q;
  logic              changed;

  logic              any;
  logic [TIME_W-1:0] best_exp;
  logic [IW-1:0]     best_idx;
  logic [IVL_W-1:0]  best_ivl;

  logic [TIME_W-1:0] rd_exp;
  logic [IVL_W-1:0]  rd_ivl;

  logic              accept;
  logic              id_ok;
  logic [IW-1:0]     req_idx;
  logic              scanning;
  logic              issue;
  logic              scan_done;
  logic              scan_enter;
  logic              out_free;
  logic              load_fire;
  logic              load_sum;
  logic [TIME_W-1:0] cmp_a;
  logic [TIME_W-1:0] cmp_b;
  logic              lt;
  logic              cand;
  logic              take;
  logic [TIME_W:0]   rearm_sum;
  logic [TIME_W-1:0] rearm_exp;
  slot_wr_t          wr;
  logic [IW-1:0]     wr_addr;
  logic [TIME_W-1:0] wr_exp;

  assign accept  = req.valid && req.ready;
  assign id_ok   = XW'(req.timer_id) < XW'(NUM_TIMERS);
  assign req_idx = IW'(req.timer_id);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          if (req.cmd == CMD_ADD && id_ok) begin
            state_next = S_PRE_SCAN;
          end else if (req.cmd == CMD_TICK) begin
            state_next = S_DUE_SCAN;
          end else begin
            state_next = S_SUM_SCAN;
          end
        end
      end
      S_PRE_SCAN: begin
        if (scan_done) begin
          state_next = S_ADD_WR;
        end
      end
      S_ADD_WR: begin
        state_next = S_SUM_SCAN;
      end
      S_DUE_SCAN: begin
        if (scan_done) begin
          state_next = S_PICK_SCAN;
        end
      end
      S_PICK_SCAN: begin
        if (scan_done) begin
          state_next = any ? S_FIRE : S_SUM_SCAN;
        end
      end
      S_FIRE: begin
        if (out_free) begin
          state_next = S_REARM;
        end
      end
      S_REARM: begin
        state_next = S_PICK_SCAN;
      end
      S_SUM_SCAN: begin
        if (scan_done) begin
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // sequencer controls
  always_comb begin
    scanning   = (state == S_PRE_SCAN) || (state == S_DUE_SCAN) ||
                 (state == S_PICK_SCAN) || (state == S_SUM_SCAN);
    issue      = scanning && (cnt != CW'(NUM_TIMERS));
    scan_done  = scanning && (cnt == CW'(NUM_TIMERS)) && !rd_valid;
    scan_enter = (state_next != state) &&
                 ((state_next == S_PRE_SCAN) || (state_next == S_DUE_SCAN) ||
                  (state_next == S_PICK_SCAN) || (state_next == S_SUM_SCAN));
    out_free   = !rsp.valid || rsp.ready;
    load_fire  = (state == S_FIRE) && out_free;
    load_sum   = (state == S_SUM) && out_free;
    req.ready  = (state == S_IDLE);
    wr.exp_en  = (state == S_ADD_WR) || ((state == S_REARM) && (best_ivl != '0));
    wr.ivl_en  = (state == S_ADD_WR);
    wr_addr    = (state == S_ADD_WR) ? id_q : best_idx;
    wr_exp     = (state == S_ADD_WR) ? time_q : rearm_exp;
  end

  // shared compare unit
  always_comb begin
    if (state == S_DUE_SCAN) begin
      cmp_a = time_q;
      cmp_b = rd_exp;
    end else begin
      cmp_a = rd_valid ? rd_exp : time_q;
      cmp_b = best_exp;
    end
    lt   = cmp_a < cmp_b;
    cand = (state == S_PICK_SCAN) ? due[rd_idx] : armed[rd_idx];
    take = rd_valid && (state != S_DUE_SCAN) && cand && (!any || lt);
  end

  assign rearm_sum = {1'b0, time_q} + (TIME_W + 1)'(best_ivl);
  assign rearm_exp = rearm_sum[TIME_W] ? TIME_MAX : rearm_sum[TIME_W-1:0];

  tes_slot_mem #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_slot_mem (
    .clk     (clk),
    .wr      (wr),
    .wr_addr (wr_addr),
    .wr_exp  (wr_exp),
    .wr_ivl  (ivl_q),
    .rd_addr (cnt[IW-1:0]),
    .rd_exp  (rd_exp),
    .rd_ivl  (rd_ivl)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rd_valid  <= 1'b0;
      armed     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= issue;
      if (scan_enter) begin
        cnt <= '0;
      end else if (issue) begin
        cnt <= cnt + 1'b1;
      end
      if (accept && req.cmd == CMD_CANCEL && id_ok) begin
        armed[req_idx] <= 1'b0;
      end
      if (state == S_ADD_WR) begin
        armed[id_q] <= 1'b1;
      end
      if (state == S_REARM && best_ivl == '0) begin
        armed[best_idx] <= 1'b0;
      end
      if (load_fire || load_sum) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= cnt[IW-1:0];
    if (accept) begin
      time_q  <= (req.cmd == CMD_ADD) ? req.expiry_time : req.now_time;
      ivl_q   <= req.repeat_interval;
      id_q    <= req_idx;
      changed <= 1'b0;
    end
    if (state == S_PRE_SCAN && scan_done) begin
      changed <= !any || lt;
    end
    if (scan_enter) begin
      any <= 1'b0;
    end else if (take) begin
      any      <= 1'b1;
      best_exp <= rd_exp;
      best_idx <= rd_idx;
      best_ivl <= rd_ivl;
    end
    if (state == S_DUE_SCAN && rd_valid) begin
      due[rd_idx] <= armed[rd_idx] && !lt;
    end
    if (load_fire) begin
      due[best_idx] <= 1'b0;
    end
    if (load_fire) begin
      rsp.fired            <= 1'b1;
      rsp.fired_id         <= ID_W'(best_idx);
      rsp.deadline_valid   <= 1'b0;
      rsp.next_deadline    <= '0;
      rsp.earliest_changed <= 1'b0;
      rsp.last             <= 1'b0;
    end else if (load_sum) begin
      rsp.fired            <= 1'b0;
      rsp.fired_id         <= '0;
      rsp.deadline_valid   <= any;
      rsp.next_deadline    <= any ? best_exp : '0;
      rsp.earliest_changed <= changed;
      rsp.last             <= 1'b1;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("sequencer stayed idle after an accepted command");

  a_read_only_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> ((state == S_PRE_SCAN) || (state == S_DUE_SCAN) ||
                  (state == S_PICK_SCAN) || (state == S_SUM_SCAN)))
    else $error("slot read returned outside a scan");

  a_fire_not_last: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.fired) |-> (!rsp.last && !rsp.deadline_valid && !rsp.earliest_changed))
    else $error("fired result carries summary fields");

  a_summary_rearm: assert property (@(posedge clk) disable iff (rst)
    load_fire |=> (state == S_REARM))
    else $error("fired slot not followed by its rearm step");

endmodule

`default_nettype wire

// ===== tb/timer_check_pkg.sv =====
package timer_check_pkg;
  import tes_pkg::*;

  localparam int NUM_SLOTS = 16;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   timer_id;
    logic [TIME_W-1:0] expiry_time;
    logic [IVL_W-1:0]  repeat_interval;
    logic [TIME_W-1:0] now_time;
  } timer_cmd_t;

  typedef struct packed {
    logic              fired;
    logic [ID_W-1:0]   fired_id;
    logic              deadline_valid;
    logic [TIME_W-1:0] next_deadline;
    logic              earliest_changed;
    logic              last;
  } timer_event_t;

  class expiry_scoreboard;
    bit                armed [NUM_SLOTS];
    logic [TIME_W-1:0] expiry [NUM_SLOTS];
    logic [IVL_W-1:0]  period [NUM_SLOTS];
    timer_event_t      expected_events [$];
    int                mismatches;
    int                checked;

    function new();
      foreach (armed[i]) begin
        armed[i] = 1'b0;
        expiry[i] = '0;
        period[i] = '0;
      end
      mismatches = 0;
      checked = 0;
    endfunction

    function int pending();
      return expected_events.size();
    endfunction

    function void queue_event(timer_event_t ev);
      expected_events.insert(expected_events.size(), ev);
    endfunction

    function bit earliest_expiry(output logic [TIME_W-1:0] t);
      bit any;
      any = 1'b0;
      t = '0;
      foreach (armed[i]) begin
        if (armed[i] && (!any || expiry[i] < t)) begin
          t = expiry[i];
          any = 1'b1;
        end
      end
      return any;
    endfunction

    // work out every event that one accepted command will produce
    function void note_command(timer_cmd_t c);
      logic [TIME_W-1:0] prev;
      logic [TIME_W:0]   sum;
      bit                any;
      bit                changed;
      bit                due [NUM_SLOTS];
      int                pick;
      timer_event_t      ev;
      changed = 1'b0;
      case (c.cmd)
        CMD_ADD: begin
          any = earliest_expiry(prev);
          if (!any || c.expiry_time < prev) changed = 1'b1;
          armed[c.timer_id] = 1'b1;
          expiry[c.timer_id] = c.expiry_time;
          period[c.timer_id] = c.repeat_interval;
        end
        CMD_CANCEL: begin
          armed[c.timer_id] = 1'b0;
        end
        CMD_TICK: begin
          // due set is frozen before any re-arm
          foreach (due[i]) due[i] = armed[i] && expiry[i] <= c.now_time;
          do begin
            pick = -1;
            foreach (due[i]) begin
              if (due[i] && (pick < 0 || expiry[i] < expiry[pick])) pick = i;
            end
            if (pick >= 0) begin
              due[pick] = 1'b0;
              ev = '0;
              ev.fired = 1'b1;
              ev.fired_id = pick[ID_W-1:0];
              queue_event(ev);
              if (period[pick] != '0) begin
                sum = c.now_time;
                sum = sum + period[pick];
                expiry[pick] = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
              end else begin
                armed[pick] = 1'b0;
              end
            end
          end while (pick >= 0);
        end
        default: begin
        end
      endcase
      ev = '0;
      ev.deadline_valid = earliest_expiry(prev);
      ev.next_deadline = ev.deadline_valid ? prev : '0;
      ev.earliest_changed = changed;
      ev.last = 1'b1;
      queue_event(ev);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 40) $display("mismatch at event %0d: %s", checked, msg);
    endtask

    task check_event(timer_event_t got);
      timer_event_t want;
      if (expected_events.size() == 0) begin
        report_mismatch("event with nothing pending");
        checked++;
        return;
      end
      want = expected_events.pop_front();
      if (got.fired !== want.fired)
        report_mismatch($sformatf("fired %0b want %0b", got.fired, want.fired));
      if (got.fired_id !== want.fired_id)
        report_mismatch($sformatf("fired_id %0d want %0d", got.fired_id, want.fired_id));
      if (got.deadline_valid !== want.deadline_valid)
        report_mismatch($sformatf("deadline_valid %0b want %0b",
                                  got.deadline_valid, want.deadline_valid));
      if (got.next_deadline !== want.next_deadline)
        report_mismatch($sformatf("next_deadline %h want %h",
                                  got.next_deadline, want.next_deadline));
      if (got.earliest_changed !== want.earliest_changed)
        report_mismatch($sformatf("earliest_changed %0b want %0b",
                                  got.earliest_changed, want.earliest_changed));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %0b want %0b", got.last, want.last));
      checked++;
    endtask
  endclass

endpackage

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tes_pkg::*;
  import timer_check_pkg::*;

  localparam int IDLE_LIMIT   = 5000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_ITEMS = 240;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tes_in_if  req_if ();
  tes_out_if rsp_if ();

  timer_expiry_scheduler_core #(.NUM_TIMERS(NUM_SLOTS)) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  expiry_scoreboard sb;
  bit               steady;
  bit               hold_req;
  bit               hold_taken;
  int               hold_left;
  logic [TIME_W-1:0] now_base;

  always #5 clk = ~clk;

  function automatic logic [TIME_W-1:0] rand_time();
    return {16'($urandom()), 32'($urandom())};
  endfunction

  function automatic timer_cmd_t random_cmd();
    timer_cmd_t c;
    c.cmd = CMD_UNUSED;
    c.timer_id = ID_W'($urandom_range(NUM_SLOTS - 1));
    c.expiry_time = rand_time();
    c.repeat_interval = $urandom();
    c.now_time = rand_time();
    return c;
  endfunction

  task automatic send_cmd(input timer_cmd_t c);
    req_if.valid <= 1'b1;
    req_if.cmd <= c.cmd;
    req_if.timer_id <= c.timer_id;
    req_if.expiry_time <= c.expiry_time;
    req_if.repeat_interval <= c.repeat_interval;
    req_if.now_time <= c.now_time;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sb.note_command(c);
    if (!steady && $urandom_range(99) < 26) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic issue(input logic [CMD_W-1:0] op, input logic [ID_W-1:0] id,
                       input logic [TIME_W-1:0] at, input logic [IVL_W-1:0] every,
                       input logic [TIME_W-1:0] now);
    timer_cmd_t c;
    c.cmd = op;
    c.timer_id = id;
    c.expiry_time = at;
    c.repeat_interval = every;
    c.now_time = now;
    send_cmd(c);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // arm every slot close together, then one tick fires them all
  task automatic fire_burst();
    timer_cmd_t c;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      c = random_cmd();
      c.cmd = CMD_ADD;
      c.timer_id = ID_W'(i);
      c.expiry_time = now_base + $urandom_range(0, 40);
      c.repeat_interval = $urandom_range(1) ? '0 : $urandom_range(1, 500);
      send_cmd(c);
    end
    c = random_cmd();
    c.cmd = CMD_TICK;
    now_base = now_base + 50;
    c.now_time = now_base;
    send_cmd(c);
  endtask

  task automatic random_item();
    timer_cmd_t c;
    int r;
    int k;
    c = random_cmd();
    r = $urandom_range(99);
    if (r < 40) begin
      c.cmd = CMD_ADD;
      if ($urandom_range(19) != 0) c.expiry_time = now_base + $urandom_range(0, 3000);
      k = $urandom_range(9);
      if (k < 4) c.repeat_interval = '0;
      else if (k < 9) c.repeat_interval = $urandom_range(1, 2000);
    end else if (r < 55) begin
      c.cmd = CMD_CANCEL;
    end else if (r < 92) begin
      c.cmd = CMD_TICK;
      if ($urandom_range(19) == 0) begin
        c.now_time = now_base - $urandom_range(0, 500);
      end else begin
        now_base = now_base + $urandom_range(0, 1200);
        c.now_time = now_base;
      end
    end else if (r < 97) begin
      c.cmd = CMD_UNUSED;
    end else begin
      // tick at a random time, leaves the time base alone
      c.cmd = CMD_TICK;
    end
    send_cmd(c);
  endtask

  // sender
  initial begin
    sb = new();
    steady = 1'b0;
    hold_req = 1'b0;
    now_base = '0;
    req_if.valid <= 1'b0;
    req_if.cmd <= CMD_ADD;
    req_if.timer_id <= '0;
    req_if.expiry_time <= '0;
    req_if.repeat_interval <= '0;
    req_if.now_time <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    issue(CMD_TICK, 0, 0, 0, 0);
    issue(CMD_CANCEL, 3, 0, 0, 0);
    issue(CMD_UNUSED, 15, TIME_MAX, '1, TIME_MAX);
    issue(CMD_ADD, 0, 100, 0, 0);
    issue(CMD_ADD, 15, 50, 25, 0);
    issue(CMD_ADD, 7, 50, 0, 0);
    issue(CMD_ADD, 3, 200, 10, 0);
    issue(CMD_ADD, 0, 60, 0, 0);
    issue(CMD_TICK, 0, 0, 0, 60);
    issue(CMD_CANCEL, 3, 0, 0, 0);
    issue(CMD_ADD, 9, TIME_MAX, '1, 0);
    issue(CMD_ADD, 10, 0, 1, 0);
    issue(CMD_TICK, 0, 0, 0, TIME_MAX - 5);
    issue(CMD_TICK, 0, 0, 0, TIME_MAX);
    issue(CMD_CANCEL, 9, 0, 0, 0);
    issue(CMD_CANCEL, 10, 0, 0, 0);
    issue(CMD_CANCEL, 15, TIME_MAX, '1, TIME_MAX);
    issue(CMD_ADD, 4, 0, 0, 0);
    issue(CMD_TICK, 15, TIME_MAX, '1, 0);

    now_base = 1000;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 150 && n < 200);
      if (n == 80) hold_req = 1'b1;
      if (n == 220) drain();
      if (n % 70 == 35) fire_burst();
      else random_item();
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // receiver
  initial begin
    timer_event_t got;
    hold_taken = 1'b0;
    hold_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_if.valid && rsp_if.ready) begin
        got = {rsp_if.fired, rsp_if.fired_id, rsp_if.deadline_valid,
               rsp_if.next_deadline, rsp_if.earliest_changed, rsp_if.last};
        sb.check_event(got);
      end
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (rst) begin
        rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (steady) begin
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= 26);
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int idle_run;
    idle_run = 0;
    while (idle_run < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_run = 0;
      else idle_run++;
    end
    $display("Simulation FAILED");
    $finish;
  end

endmodule
